FILE: rtl/core/flvd_pkg.sv
// Shared types and constants for the FLV tag deframer.
// Holds the item and result structs, kind and status codes, and parser phases.
// No dependencies.
package flvd_pkg;

  // Item action codes
  parameter logic ACT_DATA = 1'b0;
  parameter logic ACT_END  = 1'b1;

  // Result kinds
  parameter logic [2:0] KIND_FILE_HDR  = 3'd0;
  parameter logic [2:0] KIND_PREV_SIZE = 3'd1;
  parameter logic [2:0] KIND_TAG_HDR   = 3'd2;
  parameter logic [2:0] KIND_PAYLOAD   = 3'd3;
  parameter logic [2:0] KIND_BAD_SIG   = 3'd4;
  parameter logic [2:0] KIND_END       = 3'd5;

  // End-of-stream status codes
  parameter logic [1:0] END_CLEAN     = 2'd0;
  parameter logic [1:0] END_SHORT_HDR = 2'd1;
  parameter logic [1:0] END_SHORT_TAG = 2'd2;
  parameter logic [1:0] END_AFTER_ERR = 2'd3;

  // Field lengths in bytes and file and tag header byte positions
  parameter logic [23:0] FILE_HDR_BYTES = 24'd9;
  parameter logic [23:0] PREV_SIZE_LEN  = 24'd4;
  parameter logic [23:0] TAG_HDR_BYTES  = 24'd11;
  parameter logic [23:0] SIG_LEN        = 24'd3;
  parameter logic [23:0] POS_VERSION    = 24'd3;
  parameter logic [23:0] POS_FLAGS      = 24'd4;
  parameter logic [23:0] POS_TYPE       = 24'd0;
  parameter logic [23:0] POS_SIZE_END   = 24'd3;
  parameter logic [23:0] POS_TIME_END   = 24'd6;
  parameter logic [23:0] POS_TIME_EXT   = 24'd7;

  // Signature bytes "F", "L", "V"
  parameter logic [7:0] SIG_BYTE [3] = '{8'h46, 8'h4C, 8'h56};

  typedef enum logic [3:0] {
    PH_FILE    = 4'b0001,
    PH_PREV    = 4'b0010,
    PH_TAG     = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  end_status;
    logic [7:0]  version;
    logic [7:0]  flags_byte;
    logic [31:0] word_value;
    logic [7:0]  tag_type;
    logic [23:0] payload_size;
    logic [23:0] time_low;
    logic [7:0]  time_high;
    logic [23:0] stream_number;
    logic [7:0]  payload_byte;
    logic        last_of_payload;
  } result_t;

endpackage

FILE: rtl/core/flv_tag_deframer_top.sv
// Top level of the FLV tag deframer: input register, parser core, result register.
// Depends on flvd_pkg and flvd_parse.
//
// Takes an FLV file one byte per transfer, plus an end-of-stream item, and gives at
// most one result per item: file header, previous tag size, tag header, payload byte,
// bad signature or end status. One item is taken every clock while results drain;
// the transfer loads the input register, and the result is then loaded into the
// result register through the parser logic. A stall on the result side holds the
// result register and, through it, the input register.
module flv_tag_deframer_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  flvd_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output flvd_pkg::result_t result
);

  logic              held_valid;
  flvd_pkg::item_t   held_item;
  logic              advance;
  logic              take;
  logic              res_valid;
  flvd_pkg::result_t res;

  // Move on when the result register is free or being drained
  assign advance    = !result_valid || !result_stall;
  assign take       = held_valid && advance;
  assign item_stall = held_valid && !advance;

  // Hold the incoming item
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held_item <= item;
    end
  end

  flvd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  // Load the result register on each advance
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

endmodule

FILE: rtl/core/flvd_parse.sv
// Parser core of the FLV tag deframer: phase tracking, byte collection and result build.
// Depends on flvd_pkg.
module flvd_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  flvd_pkg::item_t   item,
  output logic              res_valid,
  output flvd_pkg::result_t res
);

  flvd_pkg::phase_t phase, phase_next;
  logic [23:0] field_count, field_count_next;
  logic [31:0] shift_word, shift_word_next;
  logic [7:0]  saved_version, saved_version_next;
  logic [7:0]  saved_flags, saved_flags_next;
  logic [7:0]  saved_type, saved_type_next;
  logic [23:0] saved_size, saved_size_next;
  logic [23:0] saved_time, saved_time_next;
  logic [7:0]  saved_time_ext, saved_time_ext_next;
  logic        error_seen, error_seen_next;
  logic [7:0]  b;
  logic [31:0] shifted;
  logic [23:0] count_dec;

  assign b         = item.data_byte;
  assign shifted   = {shift_word[23:0], b};
  assign count_dec = (field_count != 24'd0) ? field_count - 24'd1 : 24'd0;

  // Work out next state and the result for the item being taken
  always_comb begin
    phase_next          = phase;
    field_count_next    = field_count;
    shift_word_next     = shift_word;
    saved_version_next  = saved_version;
    saved_flags_next    = saved_flags;
    saved_type_next     = saved_type;
    saved_size_next     = saved_size;
    saved_time_next     = saved_time;
    saved_time_ext_next = saved_time_ext;
    error_seen_next     = error_seen;
    res_valid           = 1'b0;
    res                 = '0;
    if (take) begin
      if (item.action == flvd_pkg::ACT_END) begin
        // Report status and rearm for a new file
        res_valid = 1'b1;
        res.kind  = flvd_pkg::KIND_END;
        if (error_seen) begin
          res.end_status = flvd_pkg::END_AFTER_ERR;
        end else if (phase == flvd_pkg::PH_FILE) begin
          res.end_status = flvd_pkg::END_SHORT_HDR;
        end else if (phase == flvd_pkg::PH_PREV) begin
          res.end_status = flvd_pkg::END_CLEAN;
        end else if (phase == flvd_pkg::PH_TAG && field_count == 24'd0) begin
          res.end_status = flvd_pkg::END_CLEAN;
        end else begin
          res.end_status = flvd_pkg::END_SHORT_TAG;
        end
        phase_next          = flvd_pkg::PH_FILE;
        field_count_next    = '0;
        shift_word_next     = '0;
        saved_version_next  = '0;
        saved_flags_next    = '0;
        saved_type_next     = '0;
        saved_size_next     = '0;
        saved_time_next     = '0;
        saved_time_ext_next = '0;
        error_seen_next     = 1'b0;
      end else if (!error_seen) begin
        shift_word_next = shifted;
        case (phase)
          flvd_pkg::PH_FILE: begin
            if (field_count < flvd_pkg::SIG_LEN &&
                b != flvd_pkg::SIG_BYTE[field_count[1:0]]) begin
              // Bad signature: flag it and drop bytes until the end item
              error_seen_next = 1'b1;
              res_valid       = 1'b1;
              res.kind        = flvd_pkg::KIND_BAD_SIG;
            end else begin
              if (field_count == flvd_pkg::POS_VERSION) begin
                saved_version_next = b;
              end
              if (field_count == flvd_pkg::POS_FLAGS) begin
                saved_flags_next = b;
              end
              if (field_count == flvd_pkg::FILE_HDR_BYTES - 24'd1) begin
                res_valid        = 1'b1;
                res.kind         = flvd_pkg::KIND_FILE_HDR;
                res.version      = saved_version;
                res.flags_byte   = saved_flags;
                res.word_value   = shifted;
                phase_next       = flvd_pkg::PH_PREV;
                field_count_next = '0;
              end else begin
                field_count_next = field_count + 24'd1;
              end
            end
          end
          flvd_pkg::PH_PREV: begin
            if (field_count == flvd_pkg::PREV_SIZE_LEN - 24'd1) begin
              res_valid        = 1'b1;
              res.kind         = flvd_pkg::KIND_PREV_SIZE;
              res.word_value   = shifted;
              phase_next       = flvd_pkg::PH_TAG;
              field_count_next = '0;
            end else begin
              field_count_next = field_count + 24'd1;
            end
          end
          flvd_pkg::PH_TAG: begin
            if (field_count == flvd_pkg::POS_TYPE) begin
              saved_type_next = b;
            end
            if (field_count == flvd_pkg::POS_SIZE_END) begin
              saved_size_next = shifted[23:0];
            end
            if (field_count == flvd_pkg::POS_TIME_END) begin
              saved_time_next = shifted[23:0];
            end
            if (field_count == flvd_pkg::POS_TIME_EXT) begin
              saved_time_ext_next = b;
            end
            if (field_count == flvd_pkg::TAG_HDR_BYTES - 24'd1) begin
              res_valid         = 1'b1;
              res.kind          = flvd_pkg::KIND_TAG_HDR;
              res.tag_type      = saved_type;
              res.payload_size  = saved_size;
              res.time_low      = saved_time;
              res.time_high     = saved_time_ext;
              res.stream_number = shifted[23:0];
              // Skip straight to the next size field for an empty tag
              if (saved_size == 24'd0) begin
                phase_next       = flvd_pkg::PH_PREV;
                field_count_next = '0;
              end else begin
                phase_next       = flvd_pkg::PH_PAYLOAD;
                field_count_next = saved_size;
              end
            end else begin
              field_count_next = field_count + 24'd1;
            end
          end
          flvd_pkg::PH_PAYLOAD: begin
            // Pass the byte through and count down the remaining payload
            res_valid        = 1'b1;
            res.kind         = flvd_pkg::KIND_PAYLOAD;
            res.tag_type     = saved_type;
            res.payload_size = saved_size;
            res.payload_byte = b;
            field_count_next = count_dec;
            if (count_dec == 24'd0) begin
              res.last_of_payload = 1'b1;
              phase_next          = flvd_pkg::PH_PREV;
            end
          end
          default: begin
            phase_next = flvd_pkg::PH_FILE;
          end
        endcase
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= flvd_pkg::PH_FILE;
      field_count    <= '0;
      shift_word     <= '0;
      saved_version  <= '0;
      saved_flags    <= '0;
      saved_type     <= '0;
      saved_size     <= '0;
      saved_time     <= '0;
      saved_time_ext <= '0;
      error_seen     <= 1'b0;
    end else begin
      phase          <= phase_next;
      field_count    <= field_count_next;
      shift_word     <= shift_word_next;
      saved_version  <= saved_version_next;
      saved_flags    <= saved_flags_next;
      saved_type     <= saved_type_next;
      saved_size     <= saved_size_next;
      saved_time     <= saved_time_next;
      saved_time_ext <= saved_time_ext_next;
      error_seen     <= error_seen_next;
    end
  end

  // An error only ever arises while the file header is being checked
  a_err_in_file: assert property (@(posedge clk) disable iff (rst)
    error_seen |-> phase == flvd_pkg::PH_FILE)
    else $error("error flag set outside file header phase");

  // An end item rearms the parser completely
  a_end_rearms: assert property (@(posedge clk) disable iff (rst)
    take && item.action == flvd_pkg::ACT_END |=>
      phase == flvd_pkg::PH_FILE && !error_seen && field_count == 24'd0)
    else $error("end item did not rearm the parser");

  // Payload phase always has bytes still due
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == flvd_pkg::PH_PAYLOAD |-> field_count != 24'd0)
    else $error("payload phase with nothing left to count");

  // A tag header result leaves the parser in size or payload phase
  a_tag_hdr_next: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == flvd_pkg::KIND_TAG_HDR |=>
      phase == flvd_pkg::PH_PREV || phase == flvd_pkg::PH_PAYLOAD)
    else $error("tag header result with wrong following phase");

endmodule
